// File: src/esc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg - shared types and constants
// Divider control word, time constants and the month length table.
// ----------------------------------------------------------------------------
package esc_pkg;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [16:0] SECS_PER_MIN  = 17'd60;
   localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

   // quotient bits produced in each division phase
   localparam logic [5:0] DAY_STEPS  = 6'd32;
   localparam logic [5:0] HOUR_STEPS = 6'd5;
   localparam logic [5:0] MIN_STEPS  = 6'd6;

   localparam logic [3:0] LAST_MONTH = 4'd11;
   localparam logic [3:0] FEBRUARY   = 4'd1;

   typedef struct packed {
      logic load;
      logic step;
   } div_ctl_type;

   // days in month m (0 is January), leap adds a day to February
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd1:                   len = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         default:                len = 5'd31;
      endcase
      if (m == FEBRUARY && leap) begin
         len = 5'd29;
      end
      return len;
   endfunction

endpackage

// File: src/esc_serdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_serdiv - bit-serial restoring divider
// One quotient bit per step; the dividend shifts out at the top while the
// quotient shifts in at the bottom of the same register.
// ----------------------------------------------------------------------------
module esc_serdiv (
   input  logic                    clock,
   input  esc_pkg::div_ctl_type    ctl,
   input  logic [16:0]             load_rem,
   input  logic [31:0]             load_dvd,
   input  logic [16:0]             divisor,
   output logic [31:0]             quot,
   output logic [16:0]             rem
);

   logic [31:0] dvd_ff, dvd_in;
   logic [16:0] rem_ff, rem_in;
   logic [17:0] partial;
   logic [17:0] diff;
   logic        ge;

   always_comb begin
      partial = {rem_ff, dvd_ff[31]};
      diff    = partial - {1'b0, divisor};
      ge      = partial >= {1'b0, divisor};
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      if (ctl.load) begin
         rem_in = load_rem;
         dvd_in = load_dvd;
      end else if (ctl.step) begin
         rem_in = ge ? diff[16:0] : partial[16:0];
         dvd_in = {dvd_ff[30:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign quot = dvd_ff;
   assign rem  = rem_ff;

endmodule

// File: src/esc_calwalk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_calwalk - year and month walk
// Subtracts whole years, then whole months, from a day count, one per cycle.
// ----------------------------------------------------------------------------
module esc_calwalk #(
   parameter int YEAR_SPAN = 100
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] days_in,
   output logic        done,
   output logic [6:0]  year,
   output logic [3:0]  month,
   output logic [4:0]  day,
   output logic        out_of_range
);

   typedef enum logic [1:0] {W_IDLE, W_YEAR, W_MONTH} walk_state_type;

   walk_state_type state_ff;
   logic [15:0]    days_ff;
   logic [6:0]     year_ff;
   logic [3:0]     month_ff;
   logic           oor_ff;
   logic           done_ff;
   logic [8:0]     ylen;
   logic [4:0]     mlen;
   logic           leap;

   always_comb begin
      leap = (year_ff[1:0] == 2'd0);
      ylen = esc_pkg::DAYS_PER_YEAR + {8'd0, leap};
      mlen = esc_pkg::month_len(month_ff, leap);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            W_IDLE: begin
               if (start) begin
                  days_ff  <= days_in;
                  year_ff  <= '0;
                  month_ff <= '0;
                  oor_ff   <= 1'b0;
                  state_ff <= W_YEAR;
               end
            end
            W_YEAR: begin
               if (year_ff >= 7'(YEAR_SPAN)) begin
                  oor_ff   <= 1'b1;
                  done_ff  <= 1'b1;
                  state_ff <= W_IDLE;
               end else if (days_ff < {7'd0, ylen}) begin
                  state_ff <= W_MONTH;
               end else begin
                  days_ff <= days_ff - {7'd0, ylen};
                  year_ff <= year_ff + 7'd1;
               end
            end
            W_MONTH: begin
               if (month_ff == esc_pkg::LAST_MONTH || days_ff < {11'd0, mlen}) begin
                  done_ff  <= 1'b1;
                  state_ff <= W_IDLE;
               end else begin
                  days_ff  <= days_ff - {11'd0, mlen};
                  month_ff <= month_ff + 4'd1;
               end
            end
            default: state_ff <= W_IDLE;
         endcase
      end
   end

   assign done         = done_ff;
   assign year         = year_ff;
   assign month        = month_ff;
   assign day          = days_ff[4:0];
   assign out_of_range = oor_ff;

endmodule

// File: src/epoch_seconds_to_calendar_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit - seconds since 2000 to calendar time
// Splits a seconds count into year, month, day, hour, minute and second.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_seconds and raise start while busy is low; the word is taken at
//   that edge and busy rises on the next cycle. One result word follows, shown
//   for a single cycle with rsp_valid high; it must be captured then, the
//   receiver has no way to stall it.
// Sequence:
//   One bit-serial divider produces one quotient bit per cycle: first the day
//   split by 86400, then the hour by 3600, then minute and second by 60. The
//   calendar walk then subtracts whole years, then whole months, from the day
//   count, and the result word is registered on the walk's done strobe.
// Throughput:
//   One word at a time; busy drops on the cycle the result is shown, so a new
//   word can be accepted then.
// Reset:
//   Synchronous reset returns the controller to idle and drops any word in
//   flight; no result is emitted for it.
// Out of range:
//   A count at or past YEAR_SPAN years sets rsp_out_of_range, other fields 0.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit #(
   parameter int YEAR_SPAN = 100
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_seconds,
   output logic        rsp_valid,
   output logic [6:0]  rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [4:0]  rsp_hour,
   output logic [5:0]  rsp_minute,
   output logic [5:0]  rsp_second,
   output logic        rsp_out_of_range
);

   typedef enum logic [2:0] {S_IDLE, S_DAY, S_HOUR, S_MIN, S_CAL} state_type;

   state_type             state_ff;
   logic [5:0]            cnt_ff;
   logic [15:0]           days_ff;
   logic [4:0]            hour_ff;
   logic [5:0]            minute_ff;
   logic [5:0]            second_ff;
   logic                  rsp_valid_ff;
   logic [6:0]            rsp_year_ff;
   logic [3:0]            rsp_month_ff;
   logic [4:0]            rsp_day_ff;
   logic [4:0]            rsp_hour_ff;
   logic [5:0]            rsp_minute_ff;
   logic [5:0]            rsp_second_ff;
   logic                  rsp_oor_ff;

   esc_pkg::div_ctl_type  div_ctl;
   logic [16:0]           div_load_rem;
   logic [31:0]           div_load_dvd;
   logic [16:0]           divisor;
   logic [31:0]           quot;
   logic [16:0]           rem;
   logic                  day_last;
   logic                  hour_last;
   logic                  min_last;
   logic                  cal_start;
   logic                  cal_done;
   logic [6:0]            cal_year;
   logic [3:0]            cal_month;
   logic [4:0]            cal_day;
   logic                  cal_oor;

   always_comb begin
      day_last  = (state_ff == S_DAY)  && (cnt_ff == esc_pkg::DAY_STEPS);
      hour_last = (state_ff == S_HOUR) && (cnt_ff == esc_pkg::HOUR_STEPS);
      min_last  = (state_ff == S_MIN)  && (cnt_ff == esc_pkg::MIN_STEPS);
      cal_start = min_last;

      div_ctl.load = ((state_ff == S_IDLE) && start) || day_last || hour_last;
      div_ctl.step = ((state_ff == S_DAY) || (state_ff == S_HOUR) ||
                      (state_ff == S_MIN)) && !day_last && !hour_last && !min_last;

      // left-align each remainder so only the quotient bits that can be set are run
      div_load_rem = '0;
      div_load_dvd = req_seconds;
      if (day_last) begin
         div_load_rem = {5'd0, rem[16:5]};
         div_load_dvd = {rem[4:0], 27'd0};
      end else if (hour_last) begin
         div_load_rem = {6'd0, rem[16:6]};
         div_load_dvd = {rem[5:0], 26'd0};
      end

      unique case (state_ff)
         S_HOUR:  divisor = esc_pkg::SECS_PER_HOUR;
         S_MIN:   divisor = esc_pkg::SECS_PER_MIN;
         default: divisor = esc_pkg::SECS_PER_DAY;
      endcase
   end

   esc_serdiv u_div (
      .clock    (clock),
      .ctl      (div_ctl),
      .load_rem (div_load_rem),
      .load_dvd (div_load_dvd),
      .divisor  (divisor),
      .quot     (quot),
      .rem      (rem)
   );

   esc_calwalk #(
      .YEAR_SPAN (YEAR_SPAN)
   ) u_cal (
      .clock        (clock),
      .reset        (reset),
      .start        (cal_start),
      .days_in      (days_ff),
      .done         (cal_done),
      .year         (cal_year),
      .month        (cal_month),
      .day          (cal_day),
      .out_of_range (cal_oor)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  cnt_ff   <= '0;
                  state_ff <= S_DAY;
               end
            end
            S_DAY: begin
               if (day_last) begin
                  days_ff  <= quot[15:0];
                  cnt_ff   <= '0;
                  state_ff <= S_HOUR;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            S_HOUR: begin
               if (hour_last) begin
                  hour_ff  <= quot[4:0];
                  cnt_ff   <= '0;
                  state_ff <= S_MIN;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            S_MIN: begin
               if (min_last) begin
                  minute_ff <= quot[5:0];
                  second_ff <= rem[5:0];
                  state_ff  <= S_CAL;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            S_CAL: begin
               if (cal_done) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_oor_ff    <= cal_oor;
                  rsp_year_ff   <= cal_oor ? 7'd0 : cal_year;
                  rsp_month_ff  <= cal_oor ? 4'd0 : cal_month + 4'd1;
                  rsp_day_ff    <= cal_oor ? 5'd0 : cal_day + 5'd1;
                  rsp_hour_ff   <= cal_oor ? 5'd0 : hour_ff;
                  rsp_minute_ff <= cal_oor ? 6'd0 : minute_ff;
                  rsp_second_ff <= cal_oor ? 6'd0 : second_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year         = rsp_year_ff;
   assign rsp_month        = rsp_month_ff;
   assign rsp_day          = rsp_day_ff;
   assign rsp_hour         = rsp_hour_ff;
   assign rsp_minute       = rsp_minute_ff;
   assign rsp_second       = rsp_second_ff;
   assign rsp_out_of_range = rsp_oor_ff;

`ifndef SYNTHESIS
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted word");

   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_date_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_of_range ||
                     (rsp_month != 4'd0 && rsp_month <= 4'd12 && rsp_day != 5'd0)))
      else $error("month or day out of range in result");

   a_time_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_of_range ||
                     (rsp_hour < 5'd24 && rsp_minute < 6'd60 && rsp_second < 6'd60)))
      else $error("time of day out of range in result");
`endif

endmodule

// File: tb/tb_epoch_seconds_to_calendar_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_unit - self-checking bench for the calendar unit
// Feeds second counts through a start/busy driver with random hold-offs and
// checks every strobed result word against a calendar predictor kept here.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_unit;

   localparam int          SPAN          = 100;
   localparam int unsigned DAY_SECS      = 86400;
   localparam int unsigned HOUR_SECS     = 3600;
   localparam int unsigned MINUTE_SECS   = 60;
   localparam int unsigned COMMON_DAYS   = 365;
   localparam int unsigned SPAN_DAYS     = 36525;
   localparam int          RANDOM_WORDS  = 1750;
   localparam int          MAX_REPORTS   = 10;
   localparam int          DRAIN_CYCLES  = 200;

   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic       out_of_range;
   } calendar_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [31:0] req_seconds = '0;
   logic        busy;
   logic        rsp_valid;
   logic [6:0]  rsp_year;
   logic [3:0]  rsp_month;
   logic [4:0]  rsp_day;
   logic [4:0]  rsp_hour;
   logic [5:0]  rsp_minute;
   logic [5:0]  rsp_second;
   logic        rsp_out_of_range;

   logic [31:0]  pending_seconds[$];
   calendar_type expected_dates[$];
   int           mismatch_count = 0;

   epoch_seconds_to_calendar_unit #(.YEAR_SPAN(SPAN)) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_seconds     (req_seconds),
      .rsp_valid       (rsp_valid),
      .rsp_year        (rsp_year),
      .rsp_month       (rsp_month),
      .rsp_day         (rsp_day),
      .rsp_hour        (rsp_hour),
      .rsp_minute      (rsp_minute),
      .rsp_second      (rsp_second),
      .rsp_out_of_range(rsp_out_of_range)
   );

   always #5 clock = ~clock;

   // month is 0 for January
   function automatic int unsigned month_days(input int unsigned month, input bit leap);
      int unsigned len;
      case (month)
         1:          len = leap ? 29 : 28;
         3, 5, 8, 10: len = 30;
         default:    len = 31;
      endcase
      return len;
   endfunction

   // day index since the epoch of year offset y, month m (1..12), day d (1..31)
   function automatic int unsigned day_number(input int unsigned y, input int unsigned m,
                                              input int unsigned d);
      int unsigned total;
      total = d - 1;
      for (int unsigned i = 0; i < y; i++) begin
         total += COMMON_DAYS + ((i % 4 == 0) ? 1 : 0);
      end
      for (int unsigned i = 0; i + 1 < m; i++) begin
         total += month_days(i, y % 4 == 0);
      end
      return total;
   endfunction

   function automatic calendar_type calendar_of(input logic [31:0] secs);
      int unsigned  days;
      int unsigned  tod;
      int unsigned  yr;
      int unsigned  mon;
      int unsigned  len;
      calendar_type c;
      c    = '0;
      days = secs / DAY_SECS;
      tod  = secs % DAY_SECS;
      yr   = 0;
      while (yr < SPAN) begin
         len = COMMON_DAYS + ((yr % 4 == 0) ? 1 : 0);
         if (days < len) break;
         days -= len;
         yr++;
      end
      if (yr >= SPAN) begin
         c.out_of_range = 1'b1;
         return c;
      end
      mon = 0;
      while (mon < 11) begin
         len = month_days(mon, yr % 4 == 0);
         if (days < len) break;
         days -= len;
         mon++;
      end
      c.year   = yr[6:0];
      c.month  = 4'(mon + 1);
      c.day    = 5'(days + 1);
      c.hour   = 5'(tod / HOUR_SECS);
      c.minute = 6'((tod % HOUR_SECS) / MINUTE_SECS);
      c.second = 6'(tod % MINUTE_SECS);
      return c;
   endfunction

   // driver: present the next word after a random hold-off counted once busy drops
   always @(posedge clock) begin : driver
      int  hold_off;
      int  burst_left;
      bit  taken;
      if (reset) begin
         start      <= 1'b0;
         hold_off   = $urandom_range(0, 14);
         burst_left = 0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            expected_dates.push_back(calendar_of(req_seconds));
            if (burst_left > 0) begin
               burst_left--;
               hold_off = 0;
            end else begin
               hold_off = $urandom_range(0, 14);
               if ($urandom_range(0, 31) == 0) burst_left = $urandom_range(10, 40);
            end
         end
         if (!start || taken) begin
            if (hold_off > 0) begin
               start <= 1'b0;
               if (!busy) hold_off--;
            end else if (pending_seconds.size() > 0) begin
               req_seconds <= pending_seconds.pop_front();
               start       <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      calendar_type got;
      calendar_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second,
                rsp_out_of_range};
         if (expected_dates.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%t: result word with nothing pending: %p", $realtime, got);
         end else begin
            want = expected_dates.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%t: mismatch expected y=%0d m=%0d d=%0d %0d:%0d:%0d oor=%0d",
                           $realtime, want.year, want.month, want.day, want.hour,
                           want.minute, want.second, want.out_of_range);
                  $display("   got y=%0d m=%0d d=%0d %0d:%0d:%0d oor=%0d",
                           got.year, got.month, got.day, got.hour, got.minute,
                           got.second, got.out_of_range);
               end
            end
         end
      end
   end

   initial begin
      #15_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      logic [31:0] secs;
      // time-of-day edges
      pending_seconds.push_back(32'd0);
      pending_seconds.push_back(32'd1);
      pending_seconds.push_back(32'd59);
      pending_seconds.push_back(32'd60);
      pending_seconds.push_back(32'd3599);
      pending_seconds.push_back(32'd3600);
      pending_seconds.push_back(32'd86399);
      pending_seconds.push_back(32'd86400);
      // leap February and year turns
      pending_seconds.push_back(day_number(0, 2, 29) * DAY_SECS);
      pending_seconds.push_back(day_number(0, 3, 1) * DAY_SECS - 1);
      pending_seconds.push_back(day_number(0, 3, 1) * DAY_SECS);
      pending_seconds.push_back(day_number(0, 12, 31) * DAY_SECS + DAY_SECS - 1);
      pending_seconds.push_back(day_number(1, 1, 1) * DAY_SECS);
      pending_seconds.push_back(day_number(1, 3, 1) * DAY_SECS - 1);
      pending_seconds.push_back(day_number(1, 3, 1) * DAY_SECS);
      pending_seconds.push_back(day_number(96, 2, 29) * DAY_SECS + 43200);
      pending_seconds.push_back(day_number(50, 7, 15) * DAY_SECS + 45296);
      // last in-range second, first out-of-range second, and wide patterns
      pending_seconds.push_back(SPAN_DAYS * DAY_SECS - 1);
      pending_seconds.push_back(SPAN_DAYS * DAY_SECS);
      pending_seconds.push_back(32'hFFFF_FFFF);
      pending_seconds.push_back(32'h8000_0000);
      pending_seconds.push_back(32'h7FFF_FFFF);
      pending_seconds.push_back(32'h5555_5555);
      pending_seconds.push_back(32'hAAAA_AAAA);

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         case ($urandom_range(0, 7))
            0, 1, 2, 3:
               secs = $urandom_range(0, SPAN_DAYS - 1) * DAY_SECS
                      + $urandom_range(0, DAY_SECS - 1);
            4, 5:
               // first second of a month or the last second before it
               secs = day_number($urandom_range(0, SPAN - 1), $urandom_range(1, 12), 1)
                      * DAY_SECS - $urandom_range(0, 1);
            6:
               secs = SPAN_DAYS * DAY_SECS - 1 + $urandom_range(0, 2) - 1 +
                      ($urandom_range(0, 1) ? 0 : -($urandom_range(0, 200000)));
            default:
               secs = $urandom;
         endcase
         pending_seconds.push_back(secs);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_seconds.size() != 0 || start) @(posedge clock);
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_dates.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// File: epoch_seconds_to_calendar_unit.f
src/esc_pkg.sv
src/esc_serdiv.sv
src/esc_calwalk.sv
src/epoch_seconds_to_calendar_unit.sv
tb/tb_epoch_seconds_to_calendar_unit.sv
